/* hw/rtl/mtp_pkg.sv */
// mtp_pkg: types, register codes and reset constants of the mersenne twister core
// no dependencies; imported by mtp_temper and mersenne_twister_prng_core
package mtp_pkg;

    localparam int CFG_ADDR_BITS = 6;

    localparam logic [63:0] RST_TWIST  = 64'd13043109905998158313;
    localparam logic [63:0] RST_MASK_B = 64'd8202884508482404352;
    localparam logic [63:0] RST_MASK_C = 64'd18444473444759240704;
    localparam logic [63:0] RST_MASK_D = 64'd6148914691236517205;
    localparam logic [5:0]  RST_SHIFT_U = 6'd29;
    localparam logic [5:0]  RST_SHIFT_S = 6'd17;
    localparam logic [5:0]  RST_SHIFT_T = 6'd37;
    localparam logic [5:0]  RST_SHIFT_L = 6'd43;

    typedef enum logic [2:0] {
        REG_TWIST   = 3'd0,
        REG_MASK_B  = 3'd1,
        REG_MASK_C  = 3'd2,
        REG_MASK_D  = 3'd3,
        REG_SHIFT_U = 3'd4,
        REG_SHIFT_S = 3'd5,
        REG_SHIFT_T = 3'd6,
        REG_SHIFT_L = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_GEN_K,
        S_GEN_NXT,
        S_GEN_MID,
        S_GEN_WB
    } t_state;

    typedef enum logic [2:0] {
        PH_FOLD,
        PH_MUL_LL,
        PH_MUL_LH,
        PH_MUL_HL,
        PH_ACC,
        PH_WRITE
    } t_seed_phase;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SHR_U,
        T_SHL_S,
        T_SHL_T,
        T_SHR_L,
        T_FULL
    } t_tmp_state;

    typedef struct packed {
        logic [63:0] mask_b;
        logic [63:0] mask_c;
        logic [63:0] mask_d;
        logic [5:0]  shift_u;
        logic [5:0]  shift_s;
        logic [5:0]  shift_t;
        logic [5:0]  shift_l;
    } t_temper_cfg;

    function automatic logic [63:0] word_mask(input int bits);
        return (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
    endfunction

endpackage

/* hw/rtl/mtp_temper.sv */
// mtp_temper: four-step tempering unit with an output register on the result channel
// depends on mtp_pkg
module mtp_temper
    import mtp_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_word,
    input  t_temper_cfg i_cfg,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_word
);

    localparam logic [63:0] WMASK = word_mask(WORD_BITS);

    t_tmp_state  r_state, n_state;
    logic [63:0] r_word, n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_word <= n_word;
    end

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        unique case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    n_word  = i_word & WMASK;
                    n_state = T_SHR_U;
                end
            end
            T_SHR_U: begin
                n_word  = (r_word ^ (((r_word >> i_cfg.shift_u) & i_cfg.mask_d))) & WMASK;
                n_state = T_SHL_S;
            end
            T_SHL_S: begin
                n_word  = (r_word ^ (((r_word << i_cfg.shift_s) & i_cfg.mask_b))) & WMASK;
                n_state = T_SHL_T;
            end
            T_SHL_T: begin
                n_word  = (r_word ^ (((r_word << i_cfg.shift_t) & i_cfg.mask_c))) & WMASK;
                n_state = T_SHR_L;
            end
            T_SHR_L: begin
                n_word  = (r_word ^ (r_word >> i_cfg.shift_l)) & WMASK;
                n_state = T_FULL;
            end
            T_FULL: begin
                if (!i_stall) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == T_IDLE);
    assign o_valid = (r_state == T_FULL);
    assign o_word  = r_word;

    a_valid_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("temper unit ready while holding a result");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> o_ready)
        else $error("temper unit started while busy");

    a_last_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_SHR_L) |=> o_valid)
        else $error("tempered word not presented after last step");

endmodule

/* hw/rtl/mersenne_twister_prng_core.sv */
// mersenne_twister_prng_core: word store, seeding sequencer, twist and config registers
// depends on mtp_pkg and mtp_temper
//
// usage
// - input channel i_valid / o_stall carries i_cmd and i_seed; a transaction is taken
//   when i_valid is high and o_stall low. cmd 1 reseeds, cmd 0 generates one word.
// - output channel o_valid / i_stall carries o_random_word, one per generate.
// - apb port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the twist
//   matrix, tempering masks and shifts at byte address 8*index; pready is tied high.
// - seed: the first word is written at acceptance, then each further word passes the phases
//   fold, three 32x32 partial products, accumulate and write; no result.
// - generate: a transaction passes gen_k, gen_nxt and gen_mid for the three reads through
//   the word store's one read port, then write back; the core takes the next generate
//   while a word is tempered, but its write back waits for the previous word to leave
//   the tempering unit. the result is presented after write back and the tempering
//   steps shr_u, shl_s, shl_t and shr_l.
// - reset loads the mt19937-64 constants and clears the position; the word store
//   is undefined until the first seed, so seed before generating.
// - a stalled result waits in the tempering unit's output register; the core still
//   takes one more transaction and holds a generate at write back until that register frees.
module mersenne_twister_prng_core
    import mtp_pkg::*;
#(
    parameter int          WORD_BITS       = 64,
    parameter int          STATE_WORDS     = 312,
    parameter int          MIDDLE_OFFSET   = 156,
    parameter int          SPLIT_BITS      = 31,
    parameter logic [63:0] SEED_MULTIPLIER = 64'd6364136223846793005
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [63:0]              i_seed,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [63:0]              o_random_word,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [63:0]              pwdata,
    output logic [63:0]              prdata,
    output logic                     pready
);

    localparam int          AW         = (STATE_WORDS > 1) ? $clog2(STATE_WORDS) : 1;
    localparam logic [63:0] WMASK      = word_mask(WORD_BITS);
    localparam logic [63:0] LOWER_MASK = word_mask(SPLIT_BITS) & WMASK;
    localparam logic [63:0] UPPER_MASK = WMASK & ~LOWER_MASK;
    localparam int          SEED_SHIFT = WORD_BITS - 2;
    localparam logic [AW:0] WORDS_EXT  = (AW+1)'(STATE_WORDS);
    localparam logic [AW:0] MID_EXT    = (AW+1)'(MIDDLE_OFFSET % STATE_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);

    // configuration registers
    logic [63:0] r_twist, r_mask_b, r_mask_c, r_mask_d;
    logic [5:0]  r_shift_u, r_shift_s, r_shift_t, r_shift_l;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twist   <= RST_TWIST;
            r_mask_b  <= RST_MASK_B;
            r_mask_c  <= RST_MASK_C;
            r_mask_d  <= RST_MASK_D;
            r_shift_u <= RST_SHIFT_U;
            r_shift_s <= RST_SHIFT_S;
            r_shift_t <= RST_SHIFT_T;
            r_shift_l <= RST_SHIFT_L;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TWIST:   r_twist   <= pwdata;
                REG_MASK_B:  r_mask_b  <= pwdata;
                REG_MASK_C:  r_mask_c  <= pwdata;
                REG_MASK_D:  r_mask_d  <= pwdata;
                REG_SHIFT_U: r_shift_u <= pwdata[5:0];
                REG_SHIFT_S: r_shift_s <= pwdata[5:0];
                REG_SHIFT_T: r_shift_t <= pwdata[5:0];
                REG_SHIFT_L: r_shift_l <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TWIST:   prdata = r_twist;
            REG_MASK_B:  prdata = r_mask_b;
            REG_MASK_C:  prdata = r_mask_c;
            REG_MASK_D:  prdata = r_mask_d;
            REG_SHIFT_U: prdata = 64'(r_shift_u);
            REG_SHIFT_S: prdata = 64'(r_shift_s);
            REG_SHIFT_T: prdata = 64'(r_shift_t);
            REG_SHIFT_L: prdata = 64'(r_shift_l);
            default:     prdata = '0;
        endcase
    end

    // word store
    logic [WORD_BITS-1:0] r_mem [STATE_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        rd_addr;
    logic                 w_we;
    logic [AW-1:0]        w_addr;
    logic [WORD_BITS-1:0] w_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // sequencer
    t_state        r_state, n_state;
    t_seed_phase   r_phase, n_phase;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_idx, n_idx;
    logic [63:0]   r_prev, n_prev;
    logic [63:0]   r_x, n_x;
    logic [63:0]   r_pp, n_pp;
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_wk, n_wk;
    logic [63:0]   r_tw, n_tw;
    logic [63:0]   r_new, n_new;

    logic [AW-1:0] pos_nxt;
    logic [AW-1:0] pos_mid;
    logic [AW:0]   mid_sum;
    logic [AW:0]   mid_wrap;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_res;
    logic [63:0]   joined;
    logic [63:0]   seed_word;
    logic          tmp_start;
    logic          tmp_ready;
    t_temper_cfg   tmp_cfg;

    assign pos_nxt  = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
    assign mid_sum  = {1'b0, r_pos} + MID_EXT;
    assign mid_wrap = mid_sum - WORDS_EXT;
    assign pos_mid  = (mid_sum >= WORDS_EXT) ? mid_wrap[AW-1:0] : mid_sum[AW-1:0];
    assign mul_res  = mul_a * mul_b;
    assign o_stall  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FOLD;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
        end
        r_prev <= n_prev;
        r_x    <= n_x;
        r_pp   <= n_pp;
        r_acc  <= n_acc;
        r_wk   <= n_wk;
        r_tw   <= n_tw;
        r_new  <= n_new;
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_x       = r_x;
        n_pp      = r_pp;
        n_acc     = r_acc;
        n_wk      = r_wk;
        n_tw      = r_tw;
        n_new     = r_new;
        rd_addr   = r_pos;
        w_we      = 1'b0;
        w_addr    = r_pos;
        w_data    = r_new[WORD_BITS-1:0];
        tmp_start = 1'b0;
        mul_a     = r_x[31:0];
        mul_b     = SEED_MULTIPLIER[31:0];
        joined    = '0;
        seed_word = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd) begin
                        w_we    = 1'b1;
                        w_addr  = '0;
                        w_data  = i_seed[WORD_BITS-1:0];
                        n_prev  = i_seed & WMASK;
                        n_pos   = '0;
                        n_idx   = AW'(1);
                        n_phase = PH_FOLD;
                        n_state = S_SEED;
                    end else begin
                        n_state = S_GEN_K;
                    end
                end
            end
            S_SEED: begin
                unique case (r_phase)
                    PH_FOLD: begin
                        n_x     = r_prev ^ (r_prev >> SEED_SHIFT);
                        n_phase = PH_MUL_LL;
                    end
                    PH_MUL_LL: begin
                        n_pp    = mul_res;
                        n_phase = PH_MUL_LH;
                    end
                    PH_MUL_LH: begin
                        mul_b   = SEED_MULTIPLIER[63:32];
                        n_acc   = r_pp;
                        n_pp    = mul_res;
                        n_phase = PH_MUL_HL;
                    end
                    PH_MUL_HL: begin
                        mul_a   = r_x[63:32];
                        n_acc   = r_acc + {r_pp[31:0], 32'b0};
                        n_pp    = mul_res;
                        n_phase = PH_ACC;
                    end
                    PH_ACC: begin
                        n_acc   = r_acc + {r_pp[31:0], 32'b0};
                        n_phase = PH_WRITE;
                    end
                    PH_WRITE: begin
                        seed_word = (r_acc + 64'(r_idx)) & WMASK;
                        w_we      = 1'b1;
                        w_addr    = r_idx;
                        w_data    = seed_word[WORD_BITS-1:0];
                        n_prev    = seed_word;
                        n_phase   = PH_FOLD;
                        if (r_idx == LAST_IDX) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_FOLD;
                    end
                endcase
            end
            S_GEN_K: begin
                n_wk    = 64'(r_rdata);
                rd_addr = pos_nxt;
                n_state = S_GEN_NXT;
            end
            S_GEN_NXT: begin
                joined  = (r_wk & UPPER_MASK) | (64'(r_rdata) & LOWER_MASK);
                n_tw    = (joined >> 1) ^ (joined[0] ? r_twist : 64'd0);
                rd_addr = pos_mid;
                n_state = S_GEN_MID;
            end
            S_GEN_MID: begin
                n_new   = (r_tw ^ 64'(r_rdata)) & WMASK;
                n_state = S_GEN_WB;
            end
            S_GEN_WB: begin
                if (tmp_ready) begin
                    w_we      = 1'b1;
                    w_addr    = r_pos;
                    w_data    = r_new[WORD_BITS-1:0];
                    tmp_start = 1'b1;
                    n_pos     = pos_nxt;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign tmp_cfg = '{
        mask_b:  r_mask_b,
        mask_c:  r_mask_c,
        mask_d:  r_mask_d,
        shift_u: r_shift_u,
        shift_s: r_shift_s,
        shift_t: r_shift_t,
        shift_l: r_shift_l
    };

    mtp_temper #(
        .WORD_BITS (WORD_BITS)
    ) u_temper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tmp_start),
        .i_word  (r_new),
        .i_cfg   (tmp_cfg),
        .o_ready (tmp_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_random_word)
    );

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < STATE_WORDS)
        else $error("position outside word store");

    a_seed_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED) |-> (r_idx != '0 && r_idx < STATE_WORDS))
        else $error("seed index outside word store");

    a_mem_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SEED || r_state == S_GEN_WB
                  || (r_state == S_IDLE && i_valid && i_cmd)))
        else $error("unexpected word store write");

    a_wb_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN_WB && tmp_ready) |=> (r_state == S_IDLE && r_pos == $past(pos_nxt)))
        else $error("write back did not advance position");

endmodule
